FILE: hdl/ged_pkg.sv
`default_nettype none
package ged_pkg;

  // Packet header fields.
  localparam int PROTO_W = 8;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROB_W     = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_PAIR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_PORT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_TO_BAD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_TO_GOOD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_IN_GOOD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_IN_BAD    = 3'd7;

  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'h11;

  // Generator constants.
  localparam int RNG_W        = 31;
  localparam int SEED_VALUE   = 42;
  localparam int MAX_TRIES    = 5;
  localparam int TRY_W        = (MAX_TRIES > 1) ? $clog2(MAX_TRIES) : 1;
  localparam logic [31:0] LEHMER_MULT = 32'd48271;
  localparam logic [31:0] LEHMER_MOD  = 32'h7fff_ffff;
  localparam logic [31:0] DRAW_RANGE  = 32'd10000;
  localparam logic [31:0] DRAW_LIMIT  = LEHMER_MOD - (LEHMER_MOD % DRAW_RANGE);

  // floor(v / 10000) = (v * DIV_RECIP) >> DIV_SHIFT, exact for all v below 2^31.
  localparam int          DIV_SHIFT = 45;
  localparam logic [31:0] DIV_RECIP = 32'd3518437209;
  localparam int          QUOT_W    = 18;

endpackage
`default_nettype wire

FILE: hdl/ged_ifs.sv
`default_nettype none
interface ged_pkt_if;
  import ged_pkg::*;

  logic               valid;
  logic               ready;
  logic [PROTO_W-1:0] protocol;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  dst_addr;
  logic [PORT_W-1:0]  src_port;
  logic [PORT_W-1:0]  dst_port;

  modport source (output valid, protocol, src_addr, dst_addr, src_port, dst_port,
                  input ready);
  modport sink (input valid, protocol, src_addr, dst_addr, src_port, dst_port,
                output ready);
endinterface

interface ged_res_if;
  logic valid;
  logic ready;
  logic drop;

  modport source (output valid, drop, input ready);
  modport sink (input valid, drop, output ready);
endinterface
`default_nettype wire

FILE: hdl/gilbert_elliott_packet_dropper.sv
`default_nettype none
// Packet loss emulator for one watched UDP flow.
// The pkt channel carries one packet's header fields per item; the res channel
// returns one item per packet whose drop bit says whether to discard it.
// A packet that is not UDP on the watched port between the configured address
// pair is answered in the cycle after it is taken, with drop low, and the
// generator is left alone.
// A candidate packet needs one or two draws. Each draw runs one to five
// generator steps (MUL, RED) through the single 32 by 32 multiplier, then MQ
// and MR for the remainder by 10000 and CMP for the compare.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block itself does not
// enforce this. Reset (rst, synchronous) loads the register defaults, the
// generator seed and the good channel state.
// A result waits in an output register while the receiver stalls. No new
// packet is taken until that register is emptied, so a stall holds up the
// next packet.
module gilbert_elliott_packet_dropper (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ged_pkt_if.sink                             pkt,
  ged_res_if.source                           res,
  input  wire logic                           cfg_we,
  input  wire logic [ged_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ged_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ged_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;  // rng * 48271
  localparam logic [2:0] S_RED  = 3'd2;  // fold modulo 2^31-1, rejection test
  localparam logic [2:0] S_MQ   = 3'd3;  // rng * reciprocal of 10000
  localparam logic [2:0] S_MR   = 3'd4;  // quotient * 10000
  localparam logic [2:0] S_CMP  = 3'd5;  // remainder against threshold
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration registers.
  logic [63:0]        address_pair;
  logic [PORT_W-1:0]  watched_port;
  logic               loss_mode;
  logic [PROB_W-1:0]  loss_threshold;
  logic [PROB_W-1:0]  good_to_bad;
  logic [PROB_W-1:0]  bad_to_good;
  logic [PROB_W-1:0]  keep_in_good;
  logic [PROB_W-1:0]  keep_in_bad;

  // Sequencer and datapath state.
  logic [2:0]         state;
  logic [RNG_W-1:0]   rng;
  logic               channel_bad;
  logic [TRY_W-1:0]   tries;
  logic               draw_idx;
  logic               drop_flag;
  logic [63:0]        prod;
  logic               out_valid;
  logic               out_drop;

  logic               in_fire;
  logic               out_free;
  logic               load_out;
  logic               cand;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [RNG_W-1:0]   rng_src;
  logic [31:0]        fold_sum;
  logic [31:0]        fold_val;
  logic [RNG_W-1:0]   remainder;
  logic [PROB_W-1:0]  thr;
  logic               hit;

  function automatic logic [PROB_W-1:0] complement(input logic [PROB_W-1:0] keep);
    logic [PROB_W-1:0] res_val;
    res_val = (32'(keep) >= DRAW_RANGE) ? '0 : PROB_W'(DRAW_RANGE - 32'(keep));
    return res_val;
  endfunction

  assign out_free  = !out_valid || res.ready;
  assign pkt.ready = (state == S_IDLE) && out_free;
  assign in_fire   = pkt.valid && pkt.ready;
  assign res.valid = out_valid;
  assign res.drop  = out_drop;

  // The output register is loaded either by a packet that passes at once or
  // by the end of a candidate's draws.
  assign load_out = ((state == S_IDLE) && in_fire && !cand)
                 || ((state == S_DONE) && out_free);

  // A candidate is UDP on the watched port between the two addresses,
  // either way round.
  assign cand = (pkt.protocol == PROTO_UDP)
             && (pkt.src_port == watched_port || pkt.dst_port == watched_port)
             && ((address_pair[63:32] == pkt.src_addr && address_pair[31:0] == pkt.dst_addr)
              || (address_pair[63:32] == pkt.dst_addr && address_pair[31:0] == pkt.src_addr));

  // A generator at zero is reloaded with the seed when a draw begins.
  assign rng_src = (tries == '0 && rng == '0) ? RNG_W'(SEED_VALUE) : rng;

  // The one shared multiplier, with its product registered.
  always_comb begin
    case (state)
      S_MQ: begin
        mul_a = {1'b0, rng};
        mul_b = DIV_RECIP;
      end
      S_MR: begin
        mul_a = 32'(prod[DIV_SHIFT +: QUOT_W]);
        mul_b = DRAW_RANGE;
      end
      default: begin
        mul_a = {1'b0, rng_src};
        mul_b = LEHMER_MULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // Mersenne fold: high bits added back to the low 31, one subtract at most.
  assign fold_sum  = {1'b0, prod[30:0]} + 32'(prod[46:31]);
  assign fold_val  = (fold_sum >= LEHMER_MOD) ? fold_sum - LEHMER_MOD : fold_sum;
  assign remainder = rng - prod[RNG_W-1:0];

  always_comb begin
    if (!loss_mode) begin
      thr = loss_threshold;
    end else if (!draw_idx) begin
      thr = channel_bad ? complement(keep_in_bad) : complement(keep_in_good);
    end else begin
      thr = channel_bad ? bad_to_good : good_to_bad;
    end
  end

  assign hit = remainder[PROB_W-1:0] < thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_pair   <= '0;
      watched_port   <= '0;
      loss_mode      <= 1'b0;
      loss_threshold <= '0;
      good_to_bad    <= '0;
      bad_to_good    <= PROB_W'(DRAW_RANGE);
      keep_in_good   <= PROB_W'(DRAW_RANGE);
      keep_in_bad    <= PROB_W'(DRAW_RANGE);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADDRESS_PAIR:   address_pair   <= cfg_data;
        CFG_WATCHED_PORT:   watched_port   <= cfg_data[PORT_W-1:0];
        CFG_LOSS_MODE:      loss_mode      <= cfg_data[0];
        CFG_LOSS_THRESHOLD: loss_threshold <= cfg_data[PROB_W-1:0];
        CFG_GOOD_TO_BAD:    good_to_bad    <= cfg_data[PROB_W-1:0];
        CFG_BAD_TO_GOOD:    bad_to_good    <= cfg_data[PROB_W-1:0];
        CFG_KEEP_IN_GOOD:   keep_in_good   <= cfg_data[PROB_W-1:0];
        CFG_KEEP_IN_BAD:    keep_in_bad    <= cfg_data[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: a draw is one or more MUL/RED pairs, then MQ, MR and CMP.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rng         <= RNG_W'(SEED_VALUE);
      channel_bad <= 1'b0;
      tries       <= '0;
      draw_idx    <= 1'b0;
      drop_flag   <= 1'b0;
      out_valid   <= 1'b0;
      out_drop    <= 1'b0;
    end else begin
      if (out_valid && res.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (cand) begin
              state    <= S_MUL;
              tries    <= '0;
              draw_idx <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              out_drop  <= 1'b0;
            end
          end
        end
        S_MUL: begin
          state <= S_RED;
        end
        S_RED: begin
          rng <= fold_val[RNG_W-1:0];
          if (fold_val < DRAW_LIMIT || tries == TRY_W'(MAX_TRIES - 1)) begin
            state <= S_MQ;
          end else begin
            tries <= tries + 1'b1;
            state <= S_MUL;
          end
        end
        S_MQ: begin
          state <= S_MR;
        end
        S_MR: begin
          state <= S_CMP;
        end
        S_CMP: begin
          tries <= '0;
          if (!draw_idx) begin
            drop_flag <= hit;
            if (loss_mode) begin
              draw_idx <= 1'b1;
              state    <= S_MUL;
            end else begin
              state <= S_DONE;
            end
          end else begin
            if (hit) begin
              channel_bad <= !channel_bad;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_drop  <= drop_flag;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A packet that is not a candidate is answered without any draw and passes.
  a_pass_now: assert property (@(posedge clk) disable iff (rst)
    in_fire && !cand |=> out_valid && !out_drop)
    else $error("non-candidate packet not passed in the next cycle");

  // The channel state moves only at the compare of a second draw.
  a_chan_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == S_CMP && draw_idx) |=> $stable(channel_bad))
    else $error("channel state changed outside a transition draw");

  // The try counter never passes the last permitted try.
  a_try_bound: assert property (@(posedge clk) disable iff (rst)
    tries <= TRY_W'(MAX_TRIES - 1))
    else $error("generator try count out of range");

endmodule
`default_nettype wire
